// File: src/ammpd_pkg.sv
// shared types, widths and codes for the alternating min/max peak detector
package ammpd_pkg;

   localparam int SAMPLE_BITS   = 26;
   localparam int TIME_BITS     = 32;
   localparam int HOLD_BITS     = 8;
   localparam int PCT_BITS      = 7;
   localparam int FACTOR_BITS   = 8;
   localparam int COUNT_BITS    = 32;
   localparam int SUM_BITS      = 48;
   localparam int TOTAL_BITS    = 16;
   localparam int MUL_BITS      = 32;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int ACC_BITS      = 72;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [HOLD_BITS-1:0]   HOLD_RESET = 8'd15;
   localparam logic [PCT_BITS-1:0]    TOL_RESET  = 7'd30;
   localparam logic [FACTOR_BITS-1:0] PCT_FULL   = 8'd100;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_HOLD_COUNT = 1'b0;
   localparam logic CSR_IDX_TOLERANCE  = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [TIME_BITS-1:0]          time_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NE,
      ST_H0,
      ST_L0,
      ST_L1,
      ST_H1,
      ST_W0,
      ST_W1,
      ST_DRAIN,
      ST_EMIT
   } seq_state_type;

   // product destinations: x = n*elapsed, l = 100*x, h = sum*(100+p), w = sum*max(100-p,0)
   typedef enum logic [2:0] {
      OP_NONE,
      OP_NE,
      OP_H0,
      OP_H1,
      OP_L0,
      OP_L1,
      OP_W0,
      OP_W1
   } mul_op_type;

endpackage

// File: src/ammpd_req_if.sv
// input channel: one sample with its timestamp per beat
interface ammpd_req_if;
   logic                 valid;
   logic                 ready;
   ammpd_pkg::sample_type sample;
   ammpd_pkg::time_type   timestamp;

   modport source (output valid, output sample, output timestamp, input ready);
   modport sink   (input valid, input sample, input timestamp, output ready);
endinterface

// File: src/ammpd_rsp_if.sv
// result channel: one peak report per beat
interface ammpd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                peak_valid;
   ammpd_pkg::sample_type               peak_value;
   ammpd_pkg::time_type                 interval_ticks;
   logic                                interval_error;
   logic [ammpd_pkg::TOTAL_BITS-1:0]    peak_count;
   logic [ammpd_pkg::TOTAL_BITS-1:0]    error_count;

   modport source (output valid, output peak_valid, output peak_value, output interval_ticks,
                   output interval_error, output peak_count, output error_count, input ready);
   modport sink   (input valid, input peak_valid, input peak_value, input interval_ticks,
                   input interval_error, input peak_count, input error_count, output ready);
endinterface

// File: src/alternating_min_max_peak_detector_unit.sv
// alternating min/max peak detector: tracking, shared multiplier sequencer, result register
// a sample goes to ST_EMIT, if it confirms a maximum first via ST_NE, ST_H0, ST_L0, ST_L1,
// ST_H1, ST_W0, ST_W1, ST_DRAIN; ST_EMIT waits for a free result register; samples are
// taken only in ST_IDLE; the tolerance check runs seven products through one shared 32x32
// multiplier and accumulator; reset (synchronous, active high) restores hold_count 15,
// tolerance_pct 30 and the tracker to seek a minimum; no clearing pass, starts in ST_IDLE
module alternating_min_max_peak_detector_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ammpd_req_if.sink                            req_chan,
   ammpd_rsp_if.source                          rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ammpd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ammpd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ammpd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam ammpd_pkg::sample_type SMAX = {1'b0, {(ammpd_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam ammpd_pkg::sample_type SMIN = {1'b1, {(ammpd_pkg::SAMPLE_BITS-1){1'b0}}};

   // configuration
   logic [ammpd_pkg::HOLD_BITS-1:0] hold_count_ff;
   logic [ammpd_pkg::PCT_BITS-1:0]  tolerance_ff;
   logic                            csr_write;
   logic                            csr_idx;

   // tracker state
   logic                                 seeking_ff, seeking_in;
   logic [ammpd_pkg::HOLD_BITS-1:0]      hold_counter_ff, hold_counter_in;
   ammpd_pkg::sample_type                run_min_ff, run_min_in;
   ammpd_pkg::sample_type                run_max_ff, run_max_in;
   ammpd_pkg::time_type                  max_time_ff, max_time_in;
   ammpd_pkg::time_type                  prev_max_time_ff, prev_max_time_in;
   logic [ammpd_pkg::COUNT_BITS-1:0]     count_ff, count_in;
   logic [ammpd_pkg::SUM_BITS-1:0]       sum_ff, sum_in;
   logic [ammpd_pkg::TOTAL_BITS-1:0]     peaks_total_ff, peaks_total_in;
   logic [ammpd_pkg::TOTAL_BITS-1:0]     errors_total_ff, errors_total_in;
   logic                                 error_seen_ff, error_seen_in;

   // pending result of the accepted sample
   ammpd_pkg::time_type                  elapsed_ff, elapsed_in;
   logic                                 pend_valid_ff, pend_valid_in;
   ammpd_pkg::sample_type                pend_value_ff, pend_value_in;
   logic                                 pend_check_ff, pend_check_in;

   // tracking helpers
   logic                                 req_fire;
   logic [ammpd_pkg::HOLD_BITS-1:0]      hc_mid;
   logic                                 confirm;
   logic [ammpd_pkg::SUM_BITS:0]         sum_wide;

   // sequencer and shared unit
   ammpd_pkg::seq_state_type             state_ff, state_in;
   ammpd_pkg::mul_op_type                issue_op;
   ammpd_pkg::mul_op_type                op_ff;
   logic [ammpd_pkg::MUL_BITS-1:0]       mul_a, mul_b;
   logic [ammpd_pkg::PROD_BITS-1:0]      prod_ff;
   logic [ammpd_pkg::PROD_BITS-1:0]      x_ff;
   logic [ammpd_pkg::ACC_BITS-1:0]       lhs_ff, hib_ff, lob_ff;
   logic [ammpd_pkg::ACC_BITS-1:0]       acc_base, acc_addend, acc_sum, prod_ext;
   logic                                 acc_upper;
   logic [ammpd_pkg::FACTOR_BITS-1:0]    factor_hi, factor_lo;

   // result side
   logic                                 emit_load;
   logic                                 bad;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_peak_valid_ff;
   ammpd_pkg::sample_type                out_peak_value_ff;
   ammpd_pkg::time_type                  out_interval_ff;
   logic                                 out_error_ff;
   logic [ammpd_pkg::TOTAL_BITS-1:0]     out_peak_count_ff;
   logic [ammpd_pkg::TOTAL_BITS-1:0]     out_error_count_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      case (csr_idx)
         ammpd_pkg::CSR_IDX_HOLD_COUNT:
            csr_prdata = ammpd_pkg::CSR_DATA_BITS'(hold_count_ff);
         ammpd_pkg::CSR_IDX_TOLERANCE:
            csr_prdata = ammpd_pkg::CSR_DATA_BITS'(tolerance_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= ammpd_pkg::HOLD_RESET;
         tolerance_ff  <= ammpd_pkg::TOL_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            ammpd_pkg::CSR_IDX_HOLD_COUNT: hold_count_ff <= csr_pwdata[ammpd_pkg::HOLD_BITS-1:0];
            ammpd_pkg::CSR_IDX_TOLERANCE:  tolerance_ff  <= csr_pwdata[ammpd_pkg::PCT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- tracker ----------------
   assign req_chan.ready = (state_ff == ammpd_pkg::ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   always_comb begin
      seeking_in       = seeking_ff;
      run_min_in       = run_min_ff;
      run_max_in       = run_max_ff;
      max_time_in      = max_time_ff;
      prev_max_time_in = prev_max_time_ff;
      count_in         = count_ff;
      sum_in           = sum_ff;
      peaks_total_in   = peaks_total_ff;
      pend_valid_in    = 1'b0;
      pend_value_in    = '0;
      pend_check_in    = 1'b0;
      hc_mid           = hold_counter_ff;

      if (!seeking_ff) begin
         if (req_chan.sample < run_min_ff) begin
            run_min_in = req_chan.sample;
            hc_mid     = '0;
         end
      end else if (req_chan.sample > run_max_ff) begin
         run_max_in  = req_chan.sample;
         max_time_in = req_chan.timestamp;
         hc_mid      = '0;
      end
      if (hc_mid != '1) begin
         hc_mid = hc_mid + 1'b1;
      end

      confirm         = (hc_mid >= hold_count_ff);
      hold_counter_in = confirm ? '0 : hc_mid;
      elapsed_in      = max_time_in - prev_max_time_ff;
      sum_wide        = {1'b0, sum_ff} + (ammpd_pkg::SUM_BITS+1)'(elapsed_in);

      if (confirm) begin
         seeking_in = !seeking_ff;
         if (seeking_ff) begin
            count_in         = (count_ff == '1) ? count_ff : count_ff + 1'b1;
            sum_in           = sum_wide[ammpd_pkg::SUM_BITS] ? '1
                                                             : sum_wide[ammpd_pkg::SUM_BITS-1:0];
            pend_check_in    = 1'b1;
            pend_valid_in    = (count_in > ammpd_pkg::COUNT_BITS'(1));
            pend_value_in    = pend_valid_in ? run_max_in : '0;
            prev_max_time_in = max_time_in;
            run_max_in       = SMIN;
            if (pend_valid_in && peaks_total_ff != '1) begin
               peaks_total_in = peaks_total_ff + 1'b1;
            end
         end else begin
            run_min_in = SMAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeking_ff       <= 1'b0;
         hold_counter_ff  <= '0;
         run_min_ff       <= SMAX;
         run_max_ff       <= SMIN;
         max_time_ff      <= '0;
         prev_max_time_ff <= '0;
         count_ff         <= '0;
         sum_ff           <= '0;
         peaks_total_ff   <= '0;
      end else if (req_fire) begin
         seeking_ff       <= seeking_in;
         hold_counter_ff  <= hold_counter_in;
         run_min_ff       <= run_min_in;
         run_max_ff       <= run_max_in;
         max_time_ff      <= max_time_in;
         prev_max_time_ff <= prev_max_time_in;
         count_ff         <= count_in;
         sum_ff           <= sum_in;
         peaks_total_ff   <= peaks_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         elapsed_ff    <= elapsed_in;
         pend_valid_ff <= pend_valid_in;
         pend_value_ff <= pend_value_in;
         pend_check_ff <= pend_check_in;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      issue_op  = ammpd_pkg::OP_NONE;
      emit_load = 1'b0;
      case (state_ff)
         ammpd_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (confirm && seeking_ff) ? ammpd_pkg::ST_NE : ammpd_pkg::ST_EMIT;
            end
         end
         ammpd_pkg::ST_NE: begin
            issue_op = ammpd_pkg::OP_NE;
            state_in = ammpd_pkg::ST_H0;
         end
         ammpd_pkg::ST_H0: begin
            issue_op = ammpd_pkg::OP_H0;
            state_in = ammpd_pkg::ST_L0;
         end
         ammpd_pkg::ST_L0: begin
            issue_op = ammpd_pkg::OP_L0;
            state_in = ammpd_pkg::ST_L1;
         end
         ammpd_pkg::ST_L1: begin
            issue_op = ammpd_pkg::OP_L1;
            state_in = ammpd_pkg::ST_H1;
         end
         ammpd_pkg::ST_H1: begin
            issue_op = ammpd_pkg::OP_H1;
            state_in = ammpd_pkg::ST_W0;
         end
         ammpd_pkg::ST_W0: begin
            issue_op = ammpd_pkg::OP_W0;
            state_in = ammpd_pkg::ST_W1;
         end
         ammpd_pkg::ST_W1: begin
            issue_op = ammpd_pkg::OP_W1;
            state_in = ammpd_pkg::ST_DRAIN;
         end
         ammpd_pkg::ST_DRAIN: begin
            state_in = ammpd_pkg::ST_EMIT;
         end
         ammpd_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               emit_load = 1'b1;
               state_in  = ammpd_pkg::ST_IDLE;
            end
         end
         default: state_in = ammpd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ammpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- shared multiplier ----------------
   assign factor_hi = ammpd_pkg::PCT_FULL + ammpd_pkg::FACTOR_BITS'(tolerance_ff);
   // lower bound vanishes at full tolerance and above
   assign factor_lo = (ammpd_pkg::FACTOR_BITS'(tolerance_ff) < ammpd_pkg::PCT_FULL)
                    ? ammpd_pkg::PCT_FULL - ammpd_pkg::FACTOR_BITS'(tolerance_ff) : '0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (issue_op)
         ammpd_pkg::OP_NE: begin
            mul_a = count_ff;
            mul_b = ammpd_pkg::MUL_BITS'(elapsed_ff);
         end
         ammpd_pkg::OP_H0: begin
            mul_a = sum_ff[ammpd_pkg::MUL_BITS-1:0];
            mul_b = ammpd_pkg::MUL_BITS'(factor_hi);
         end
         ammpd_pkg::OP_H1: begin
            mul_a = ammpd_pkg::MUL_BITS'(sum_ff[ammpd_pkg::SUM_BITS-1:ammpd_pkg::MUL_BITS]);
            mul_b = ammpd_pkg::MUL_BITS'(factor_hi);
         end
         ammpd_pkg::OP_L0: begin
            mul_a = x_ff[ammpd_pkg::MUL_BITS-1:0];
            mul_b = ammpd_pkg::MUL_BITS'(ammpd_pkg::PCT_FULL);
         end
         ammpd_pkg::OP_L1: begin
            mul_a = x_ff[ammpd_pkg::PROD_BITS-1:ammpd_pkg::MUL_BITS];
            mul_b = ammpd_pkg::MUL_BITS'(ammpd_pkg::PCT_FULL);
         end
         ammpd_pkg::OP_W0: begin
            mul_a = sum_ff[ammpd_pkg::MUL_BITS-1:0];
            mul_b = ammpd_pkg::MUL_BITS'(factor_lo);
         end
         ammpd_pkg::OP_W1: begin
            mul_a = ammpd_pkg::MUL_BITS'(sum_ff[ammpd_pkg::SUM_BITS-1:ammpd_pkg::MUL_BITS]);
            mul_b = ammpd_pkg::MUL_BITS'(factor_lo);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= ammpd_pkg::OP_NONE;
      end else begin
         op_ff <= issue_op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // accumulate the registered product, upper halves shifted by one word
   assign prod_ext = ammpd_pkg::ACC_BITS'(prod_ff);

   always_comb begin
      acc_base  = '0;
      acc_upper = 1'b0;
      case (op_ff)
         ammpd_pkg::OP_H1: begin
            acc_base  = hib_ff;
            acc_upper = 1'b1;
         end
         ammpd_pkg::OP_L1: begin
            acc_base  = lhs_ff;
            acc_upper = 1'b1;
         end
         ammpd_pkg::OP_W1: begin
            acc_base  = lob_ff;
            acc_upper = 1'b1;
         end
         default: ;
      endcase
      acc_addend = acc_upper ? (prod_ext << ammpd_pkg::MUL_BITS) : prod_ext;
      acc_sum    = acc_base + acc_addend;
   end

   always_ff @(posedge clock) begin
      case (op_ff)
         ammpd_pkg::OP_NE:                   x_ff   <= prod_ff;
         ammpd_pkg::OP_H0, ammpd_pkg::OP_H1: hib_ff <= acc_sum;
         ammpd_pkg::OP_L0, ammpd_pkg::OP_L1: lhs_ff <= acc_sum;
         ammpd_pkg::OP_W0, ammpd_pkg::OP_W1: lob_ff <= acc_sum;
         default: ;
      endcase
   end

   // ---------------- interval check and result register ----------------
   always_comb begin
      bad             = pend_check_ff && ((lhs_ff > hib_ff) || (lhs_ff < lob_ff));
      error_seen_in   = error_seen_ff | bad;
      errors_total_in = errors_total_ff;
      // first out-of-range interval only arms the flag
      if (bad && error_seen_ff && errors_total_ff != '1) begin
         errors_total_in = errors_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_seen_ff   <= 1'b0;
         errors_total_ff <= '0;
      end else if (emit_load) begin
         error_seen_ff   <= error_seen_in;
         errors_total_ff <= errors_total_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_peak_valid_ff  <= pend_valid_ff;
         out_peak_value_ff  <= pend_value_ff;
         out_interval_ff    <= pend_valid_ff ? elapsed_ff : '0;
         out_error_ff       <= bad & error_seen_ff & pend_valid_ff;
         out_peak_count_ff  <= peaks_total_ff;
         out_error_count_ff <= errors_total_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.peak_valid     = out_peak_valid_ff;
   assign rsp_chan.peak_value     = out_peak_value_ff;
   assign rsp_chan.interval_ticks = out_interval_ff;
   assign rsp_chan.interval_error = out_error_ff;
   assign rsp_chan.peak_count     = out_peak_count_ff;
   assign rsp_chan.error_count    = out_error_count_ff;

endmodule
